[hdl/ntla_pkg.sv]
// Shared types and constants for the node table lookup-or-allocate block.
// Depends on nothing; imported by ntla_store, node_table_lookup_or_allocate and the testbench.
package ntla_pkg;

   localparam int ADDR_W  = 48;
   localparam int TEMP_W  = 16;
   localparam int HUM_W   = 16;
   localparam int SEQ_W   = 16;
   localparam int UP_W    = 32;
   localparam int SIG_W   = 8;
   localparam int TIME_W  = 48;
   localparam int SLOT_W  = 3;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // One table entry as held in the store.
   typedef struct packed {
      logic        [ADDR_W-1:0] address;
      logic signed [TEMP_W-1:0] temperature;
      logic        [HUM_W-1:0]  humidity;
      logic        [SEQ_W-1:0]  sequence_num;
      logic        [UP_W-1:0]   uptime;
      logic signed [SIG_W-1:0]  signal;
      logic        [TIME_W-1:0] arrival;
   } ntla_record_type;

endpackage

[hdl/ntla_store.sv]
// Entry store: single write port, one registered read port, and per-entry valid flags.
// Depends on ntla_pkg for the entry record type.
module ntla_store #(
   parameter int ENTRIES = 6,
   parameter int IDX_W   = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_idx,
   input  ntla_pkg::ntla_record_type wr_rec,
   input  logic [IDX_W-1:0]          rd_idx,
   output ntla_pkg::ntla_record_type rd_rec,
   output logic [ENTRIES-1:0]        valid_vec
);
   import ntla_pkg::*;

   ntla_record_type    mem_ff [ENTRIES];
   ntla_record_type    rd_rec_ff;
   logic [ENTRIES-1:0] valid_ff;

   // Entry contents carry no reset; only the valid flags are cleared.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_rec;
      end
      rd_rec_ff <= mem_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_rec    = rd_rec_ff;
   assign valid_vec = valid_ff;

endmodule

[hdl/node_table_lookup_or_allocate.sv]
// An update compares the entries in order from entry 0 and responds on the first hit or after the
// last entry; a read in range passes through ST_READ_WAIT before it responds,
// and a read beyond the table raises rsp_valid on the accepting edge itself.
// Throughput: one transaction at a time; a new request is taken only in ST_IDLE, once the
// previous response has been accepted with rsp_ready high.
// Reset is synchronous and active high; it clears the valid flags and the control state only.
module node_table_lookup_or_allocate #(
   parameter int TABLE_ENTRIES = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [2:0]  req_read_index,
   input  logic [47:0] req_station_address,
   input  logic signed [15:0] req_temperature_tenths,
   input  logic [15:0] req_humidity_tenths,
   input  logic [15:0] req_sequence_number,
   input  logic [31:0] req_uptime_seconds,
   input  logic signed [7:0] req_signal_strength,
   input  logic [47:0] req_arrival_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_is_new,
   output logic        rsp_dropped,
   output logic        rsp_entry_valid,
   output logic [47:0] rsp_entry_address,
   output logic signed [15:0] rsp_entry_temperature,
   output logic [15:0] rsp_entry_humidity,
   output logic [15:0] rsp_entry_sequence,
   output logic [31:0] rsp_entry_uptime,
   output logic signed [7:0] rsp_entry_signal,
   output logic [47:0] rsp_entry_time
);
   import ntla_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   state_type           state_ff;
   ntla_record_type     req_rec_ff;
   logic [2:0]          rindex_ff;
   logic [IDX_W-1:0]    issue_idx_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_is_new_ff;
   logic                rsp_dropped_ff;
   logic                rsp_entry_valid_ff;
   ntla_record_type     rsp_rec_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [IDX_W-1:0]    rd_idx;
   ntla_record_type     rd_rec;
   logic [TABLE_ENTRIES-1:0] valid_vec;

   logic                accept;
   logic                cur_valid;
   logic                hit;
   logic                at_last;
   logic                alloc;
   logic                read_in_range;
   ntla_record_type     in_rec;

   ntla_store #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_rec    (req_rec_ff),
      .rd_idx    (rd_idx),
      .rd_rec    (rd_rec),
      .valid_vec (valid_vec)
   );

   assign accept        = req_valid && (state_ff == ST_IDLE);
   assign read_in_range = 32'(req_read_index) < TABLE_ENTRIES;

   always_comb begin
      in_rec.address      = req_station_address;
      in_rec.temperature  = req_temperature_tenths;
      in_rec.humidity     = req_humidity_tenths;
      in_rec.sequence_num = req_sequence_number;
      in_rec.uptime       = req_uptime_seconds;
      in_rec.signal       = req_signal_strength;
      in_rec.arrival      = req_arrival_time;
   end

   // The read address is issued in the cycle before its compare; entry 0 goes out on acceptance.
   always_comb begin
      if (state_ff == ST_SCAN) begin
         rd_idx = issue_idx_ff;
      end else if (req_command == CMD_READ) begin
         rd_idx = IDX_W'(req_read_index);
      end else begin
         rd_idx = '0;
      end
   end

   // Shared comparator: one stored address against the key per cycle.
   assign cur_valid = valid_vec[cmp_idx_ff];
   assign hit       = cur_valid && (rd_rec.address == req_rec_ff.address);
   assign at_last   = (cmp_idx_ff == LAST_IDX);
   assign alloc     = at_last && !hit && (free_found_ff || !cur_valid);

   always_comb begin
      wr_en  = (state_ff == ST_SCAN) && (hit || alloc);
      wr_idx = (hit || !free_found_ff) ? cmp_idx_ff : free_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_rec_ff    <= in_rec;
                  rindex_ff     <= req_read_index;
                  free_found_ff <= 1'b0;
                  if (req_command == CMD_READ) begin
                     cmp_idx_ff <= IDX_W'(req_read_index);
                     if (read_in_range) begin
                        state_ff <= ST_READ_WAIT;
                     end else begin
                        rsp_slot_ff        <= req_read_index;
                        rsp_is_new_ff      <= 1'b0;
                        rsp_dropped_ff     <= 1'b0;
                        rsp_entry_valid_ff <= 1'b0;
                        rsp_rec_ff         <= '0;
                        rsp_valid_ff       <= 1'b1;
                        state_ff           <= ST_RESP;
                     end
                  end else begin
                     cmp_idx_ff   <= '0;
                     issue_idx_ff <= (TABLE_ENTRIES > 1) ? IDX_W'(1) : '0;
                     state_ff     <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               cmp_idx_ff <= issue_idx_ff;
               if (issue_idx_ff != LAST_IDX) begin
                  issue_idx_ff <= issue_idx_ff + 1'b1;
               end
               if (!free_found_ff && !cur_valid) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= cmp_idx_ff;
               end
               if (hit || at_last) begin
                  rsp_is_new_ff      <= !hit && alloc;
                  rsp_dropped_ff     <= !hit && !alloc;
                  rsp_slot_ff        <= (hit || alloc) ? SLOT_W'(wr_idx) : '0;
                  rsp_entry_valid_ff <= 1'b0;
                  rsp_rec_ff         <= '0;
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= ST_RESP;
               end
            end
            ST_READ_WAIT: begin
               rsp_slot_ff        <= rindex_ff;
               rsp_is_new_ff      <= 1'b0;
               rsp_dropped_ff     <= 1'b0;
               rsp_entry_valid_ff <= cur_valid;
               rsp_rec_ff         <= rd_rec;
               rsp_valid_ff       <= 1'b1;
               state_ff           <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_slot_index        = rsp_slot_ff;
   assign rsp_is_new            = rsp_is_new_ff;
   assign rsp_dropped           = rsp_dropped_ff;
   assign rsp_entry_valid       = rsp_entry_valid_ff;
   assign rsp_entry_address     = rsp_rec_ff.address;
   assign rsp_entry_temperature = rsp_rec_ff.temperature;
   assign rsp_entry_humidity    = rsp_rec_ff.humidity;
   assign rsp_entry_sequence    = rsp_rec_ff.sequence_num;
   assign rsp_entry_uptime      = rsp_rec_ff.uptime;
   assign rsp_entry_signal      = rsp_rec_ff.signal;
   assign rsp_entry_time        = rsp_rec_ff.arrival;

`ifndef ASSERT_OFF
   // A new transaction is never taken while a response is still on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // A written entry is marked in use from the next cycle on.
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_vec[$past(wr_idx)])
      else $error("written entry not marked valid");

   // A drop is only reported when every entry is in use.
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (&valid_vec))
      else $error("transaction dropped with a free entry");

   a_new_or_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_new && rsp_dropped))
      else $error("response flags both new and dropped");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for node_table_lookup_or_allocate: directed and random telemetry traffic,
// checked against a cycle-free model of the node table. Depends on ntla_pkg and the block's RTL.
module testbench;
   import ntla_pkg::*;

   localparam int NODE_SLOTS  = 6;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct packed {
      logic                     command;
      logic [2:0]               read_index;
      logic [ADDR_W-1:0]        station_address;
      logic signed [TEMP_W-1:0] temperature;
      logic [HUM_W-1:0]         humidity;
      logic [SEQ_W-1:0]         sequence_num;
      logic [UP_W-1:0]          uptime;
      logic signed [SIG_W-1:0]  signal;
      logic [TIME_W-1:0]        arrival;
      logic                     drain_first;
   } telemetry_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              is_new;
      logic              dropped;
      logic              entry_valid;
      ntla_record_type   entry;
   } table_reply_type;

   typedef struct packed {
      logic [NODE_SLOTS-1:0]                  in_use;
      ntla_record_type [NODE_SLOTS-1:0]       rec;
   } node_table_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_command = CMD_UPDATE;
   logic [2:0]               req_read_index = '0;
   logic [ADDR_W-1:0]        req_station_address = '0;
   logic signed [TEMP_W-1:0] req_temperature_tenths = '0;
   logic [HUM_W-1:0]         req_humidity_tenths = '0;
   logic [SEQ_W-1:0]         req_sequence_number = '0;
   logic [UP_W-1:0]          req_uptime_seconds = '0;
   logic signed [SIG_W-1:0]  req_signal_strength = '0;
   logic [TIME_W-1:0]        req_arrival_time = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [SLOT_W-1:0]        rsp_slot_index;
   logic                     rsp_is_new;
   logic                     rsp_dropped;
   logic                     rsp_entry_valid;
   logic [ADDR_W-1:0]        rsp_entry_address;
   logic signed [TEMP_W-1:0] rsp_entry_temperature;
   logic [HUM_W-1:0]         rsp_entry_humidity;
   logic [SEQ_W-1:0]         rsp_entry_sequence;
   logic [UP_W-1:0]          rsp_entry_uptime;
   logic signed [SIG_W-1:0]  rsp_entry_signal;
   logic [TIME_W-1:0]        rsp_entry_time;

   telemetry_item_type telemetry_backlog[$];
   table_reply_type    pending_replies[$];
   node_table_type     node_shadow;
   node_table_type     plan_table;

   int req_issued     = 0;
   int req_accepted   = 0;
   int replies_seen   = 0;
   int failures       = 0;
   int quiet_cycles   = 0;

   node_table_lookup_or_allocate #(
      .TABLE_ENTRIES(NODE_SLOTS)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_read_index        (req_read_index),
      .req_station_address   (req_station_address),
      .req_temperature_tenths(req_temperature_tenths),
      .req_humidity_tenths   (req_humidity_tenths),
      .req_sequence_number   (req_sequence_number),
      .req_uptime_seconds    (req_uptime_seconds),
      .req_signal_strength   (req_signal_strength),
      .req_arrival_time      (req_arrival_time),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_is_new            (rsp_is_new),
      .rsp_dropped           (rsp_dropped),
      .rsp_entry_valid       (rsp_entry_valid),
      .rsp_entry_address     (rsp_entry_address),
      .rsp_entry_temperature (rsp_entry_temperature),
      .rsp_entry_humidity    (rsp_entry_humidity),
      .rsp_entry_sequence    (rsp_entry_sequence),
      .rsp_entry_uptime      (rsp_entry_uptime),
      .rsp_entry_signal      (rsp_entry_signal),
      .rsp_entry_time        (rsp_entry_time)
   );

   always #1 clock = ~clock;

   // Applies one transaction to a copy of the table and gives the reply it should produce.
   function automatic table_reply_type lookup_or_allocate(input node_table_type now,
         input telemetry_item_type item, output node_table_type next);
      table_reply_type reply;
      int hit;
      int free_slot;
      reply = '0;
      next = now;
      hit = -1;
      free_slot = -1;
      if (item.command == CMD_READ) begin
         reply.slot = item.read_index;
         if (item.read_index < NODE_SLOTS) begin
            reply.entry_valid = now.in_use[item.read_index];
            reply.entry = now.rec[item.read_index];
         end
      end else begin
         for (int i = 0; i < NODE_SLOTS; i++) begin
            if (hit < 0 && now.in_use[i] && now.rec[i].address == item.station_address)
               hit = i;
            else if (hit < 0 && !now.in_use[i] && free_slot < 0)
               free_slot = i;
         end
         if (hit < 0 && free_slot >= 0) begin
            hit = free_slot;
            reply.is_new = 1'b1;
            next.in_use[hit] = 1'b1;
            next.rec[hit].address = item.station_address;
         end
         if (hit < 0) begin
            reply.dropped = 1'b1;
         end else begin
            next.rec[hit].temperature  = item.temperature;
            next.rec[hit].humidity     = item.humidity;
            next.rec[hit].sequence_num = item.sequence_num;
            next.rec[hit].uptime       = item.uptime;
            next.rec[hit].signal       = item.signal;
            next.rec[hit].arrival      = item.arrival;
            reply.slot = SLOT_W'(hit);
         end
      end
      return reply;
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   function automatic telemetry_item_type make_update(input logic [ADDR_W-1:0] address);
      telemetry_item_type item;
      item.command         = CMD_UPDATE;
      item.read_index      = 3'($urandom);
      item.station_address = address;
      item.temperature     = TEMP_W'($urandom);
      item.humidity        = HUM_W'($urandom);
      item.sequence_num    = SEQ_W'($urandom);
      item.uptime          = $urandom;
      item.signal          = SIG_W'(-int'($urandom_range(128)));
      item.arrival         = TIME_W'({$urandom, $urandom});
      item.drain_first     = 1'b0;
      return item;
   endfunction

   function automatic telemetry_item_type make_read(input logic [2:0] index);
      telemetry_item_type item;
      item = make_update(random_address());
      item.command = CMD_READ;
      item.read_index = index;
      return item;
   endfunction

   // The plan copy of the table tells the generator which entries hold data, so that a read
   // never lands on an entry that has not been written yet.
   task automatic queue_item(input telemetry_item_type item);
      void'(lookup_or_allocate(plan_table, item, plan_table));
      telemetry_backlog.push_back(item);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
         input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         failures++;
      end
   endtask

   // Driver: presents the next pending transaction once the previous one has been taken.
   always @(negedge clock) begin
      telemetry_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_issued == req_accepted) begin
         if (telemetry_backlog.size() == 0
               || (telemetry_backlog[0].drain_first && pending_replies.size() != 0)
               || (!(req_issued >= 300 && req_issued < 560) && $urandom_range(99) < 24)) begin
            req_valid <= 1'b0;
         end else begin
            item = telemetry_backlog.pop_front();
            req_command            <= item.command;
            req_read_index         <= item.read_index;
            req_station_address    <= item.station_address;
            req_temperature_tenths <= item.temperature;
            req_humidity_tenths    <= item.humidity;
            req_sequence_number    <= item.sequence_num;
            req_uptime_seconds     <= item.uptime;
            req_signal_strength    <= item.signal;
            req_arrival_time       <= item.arrival;
            req_valid              <= 1'b1;
            req_issued             <= req_issued + 1;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (replies_seen >= 300 && replies_seen < 560) || $urandom_range(99) >= 24;
   end

   // Monitor: checks each response against the oldest expectation, then predicts for the
   // transaction accepted on this edge.
   always @(posedge clock) begin
      telemetry_item_type seen;
      table_reply_type want;
      if (reset) begin
         node_shadow = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
               $display("%0t: response with nothing expected, slot %0d", $time,
                        rsp_slot_index);
               failures++;
            end else begin
               want = pending_replies.pop_front();
               check_field("slot_index", 64'(want.slot), 64'(rsp_slot_index));
               check_field("is_new", 64'(want.is_new), 64'(rsp_is_new));
               check_field("dropped", 64'(want.dropped), 64'(rsp_dropped));
               check_field("entry_valid", 64'(want.entry_valid), 64'(rsp_entry_valid));
               check_field("entry_address", 64'(want.entry.address),
                           64'(rsp_entry_address));
               check_field("entry_temperature", 64'(want.entry.temperature),
                           64'(rsp_entry_temperature));
               check_field("entry_humidity", 64'(want.entry.humidity),
                           64'(rsp_entry_humidity));
               check_field("entry_sequence", 64'(want.entry.sequence_num),
                           64'(rsp_entry_sequence));
               check_field("entry_uptime", 64'(want.entry.uptime), 64'(rsp_entry_uptime));
               check_field("entry_signal", 64'(want.entry.signal), 64'(rsp_entry_signal));
               check_field("entry_time", 64'(want.entry.arrival), 64'(rsp_entry_time));
            end
         end
         if (req_valid && req_ready) begin
            req_accepted++;
            seen.command         = req_command;
            seen.read_index      = req_read_index;
            seen.station_address = req_station_address;
            seen.temperature     = req_temperature_tenths;
            seen.humidity        = req_humidity_tenths;
            seen.sequence_num    = req_sequence_number;
            seen.uptime          = req_uptime_seconds;
            seen.signal          = req_signal_strength;
            seen.arrival         = req_arrival_time;
            seen.drain_first     = 1'b0;
            want = lookup_or_allocate(node_shadow, seen, node_shadow);
            pending_replies.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      telemetry_item_type item;
      int pick;
      int slot;
      logic [2:0] index;
      int total;
      localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
      localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

      plan_table = '0;

      // Out-of-range reads on the empty table.
      queue_item(make_read(3'd6));
      queue_item(make_read(3'd7));

      // First node with every field at its minimum, second with every field but the signal at its maximum.
      item = make_update(ADDR_ZERO);
      item.temperature = 16'sh8000;
      item.humidity = '0;
      item.sequence_num = '0;
      item.uptime = '0;
      item.signal = -8'sd128;
      item.arrival = '0;
      queue_item(item);
      item = make_update(ADDR_ONES);
      item.temperature = 16'sh7fff;
      item.humidity = '1;
      item.sequence_num = '1;
      item.uptime = '1;
      item.signal = '0;
      item.arrival = '1;
      queue_item(item);
      queue_item(make_read(3'd0));
      queue_item(make_read(3'd1));

      // Hit on an existing node overwrites its telemetry.
      queue_item(make_update(ADDR_ZERO));
      queue_item(make_read(3'd0));

      // Fill the remaining entries, then miss with the table full.
      queue_item(make_update(48'haaaa_aaaa_aaaa));
      queue_item(make_update(48'h5555_5555_5555));
      queue_item(make_update(48'h0000_0000_0001));
      queue_item(make_update(48'h8000_0000_0000));
      queue_item(make_update(48'h0000_0000_0002));
      queue_item(make_update(48'hffff_ffff_fffe));
      queue_item(make_read(3'd5));
      queue_item(make_read(3'd2));

      item = make_update(48'h8000_0000_0000);
      item.temperature = 16'sh7fff;
      item.signal = '0;
      queue_item(item);
      queue_item(make_read(3'd5));
      queue_item(make_read(3'd3));
      queue_item(make_read(3'd4));

      // Mostly updates of known nodes, some near-miss and unknown addresses, and reads.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         slot = $urandom_range(NODE_SLOTS - 1);
         if (pick < 25) begin
            index = 3'($urandom_range(7));
            if (index < NODE_SLOTS && !plan_table.in_use[index])
               index = 3'(NODE_SLOTS + $urandom_range(1));
            item = make_read(index);
         end else if (pick < 80 && plan_table.in_use[slot]) begin
            item = make_update(plan_table.rec[slot].address);
         end else if (pick < 90 && plan_table.in_use[slot]) begin
            item = make_update(plan_table.rec[slot].address
                               ^ (48'h1 << $urandom_range(ADDR_W - 1)));
         end else begin
            item = make_update(random_address());
         end
         item.drain_first = (n == 700);
         queue_item(item);
      end
      total = telemetry_backlog.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (req_accepted == total && pending_replies.size() == 0);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[node_table_lookup_or_allocate.f]
hdl/ntla_pkg.sv
hdl/ntla_store.sv
hdl/node_table_lookup_or_allocate.sv
bench/testbench.sv
